[design/ppmd_pkg.sv]
// Shared types and constants for the PPM decoder with vote filter.
// Used by ppmd_alu and ppm_decoder_with_vote_filter; no dependencies.
package ppmd_pkg;

	localparam int TP_W      = 16;               // timer_period width, multiply steps
	localparam int STEP_W    = $clog2(TP_W);
	localparam int CFG_IDX_W = 8;
	localparam int CFG_W     = 16;
	localparam int HDEPTH    = 3;
	localparam int EDGE_W    = 7;

	localparam logic [EDGE_W-1:0] EDGE_SAT = 7'd100;

	localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP     = 8'd3;

	localparam logic [CFG_W-1:0] TIMER_PERIOD_RST = 16'd10000;
	localparam logic [CFG_W-1:0] PULSE_MIN_RST    = 16'd800;
	localparam logic [CFG_W-1:0] PULSE_MAX_RST    = 16'd2200;
	localparam logic [CFG_W-1:0] SYNC_GAP_RST     = 16'd2500;

	// input tdata, lowest field last in the list
	typedef struct packed {
		logic [15:0] counter_value;
		logic [31:0] period_count;
	} in_data_t;

	// output tdata, lowest field last in the list
	typedef struct packed {
		logic [4:0]        pad;
		logic [EDGE_W-1:0] edge_count;
		logic [3:0]        captured_count;
		logic              synced;
		logic [31:0]       pulse_width;
		logic [11:0]       channel_value;
		logic [2:0]        channel_index;
	} out_data_t;

	// shared add/subtract unit
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        carry;    // on subtract: a >= b
	} alu_rsp_t;

endpackage

[design/ppmd_alu.sv]
// Shared 32-bit adder/subtractor with carry out, used for multiply steps,
// timestamp math, the window and gap compares and the vote's max select. Depends on ppmd_pkg.
module ppmd_alu (
	input  ppmd_pkg::alu_req_t req,
	output ppmd_pkg::alu_rsp_t rsp
);

	logic [32:0] full;

	assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + 33'(req.sub);

	assign rsp.sum   = full[31:0];
	assign rsp.carry = full[32];

endmodule

[design/ppm_decoder_with_vote_filter.sv]
// PPM frame decoder with 3-deep per-channel vote filter.
// Depends on ppmd_pkg and ppmd_alu.
//
//  channel | dir | handshake              | payload
//  s_*     | in  | s_tvalid / s_tready    | tdata: period_count, counter_value; tuser: mode
//  m_*     | out | m_tvalid / m_tready    | tdata: result fields; tuser: is_channel; tlast
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Edge item: 16 multiply steps and 5 add/compare steps on the shared adder, then
// one update step and one emit step that loads the output register; the next
// input transfer waits until the result is emitted. Sample item: one history
// push step, then one vote per channel per cycle on the shared adder while the
// output register is free; the next input transfer waits for the last vote.
// Output stall holds the sequencer at its emit or vote step. Reset clears all
// state; no clearing pass. s_tready is high only while the sequencer is idle.
module ppm_decoder_with_vote_filter #(
	parameter int CHANNELS   = 8,
	parameter int VALUE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // period_count[31:0], counter_value[47:32]
	input  logic [0:0]  s_tuser,    // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // channel_index[2:0], channel_value[14:3],
	                                // pulse_width[46:15], synced[47],
	                                // captured_count[51:48], edge_count[58:52]
	output logic [0:0]  m_tuser,    // is_channel
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ppmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppmd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = $clog2(CHANNELS + 1);
	localparam logic [31:0] VALUE_MAX = 32'((64'd1 << VALUE_BITS) - 64'd1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_ADDCV, ST_DELTA, ST_CMIN, ST_CMAX, ST_CGAP,
		ST_UPD, ST_EMIT, ST_PUSH, ST_VOTE
	} state_t;

	state_t state_q;

	logic [ppmd_pkg::CFG_W-1:0] tp_q, pmin_q, pmax_q, gap_q;

	logic [31:0]                 acc_q, mcand_q, prev_q, delta_q;
	logic [ppmd_pkg::TP_W-1:0]   mplier_q;
	logic [15:0]                 cv_q;
	logic [ppmd_pkg::STEP_W-1:0] step_q;
	logic                        ge_min_q, le_max_q, ge_gap_q;

	logic                        sync_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [ppmd_pkg::EDGE_W-1:0] edges_q;
	logic [1:0]                  hslot_q;
	logic [CH_W-1:0]             chan_q;

	logic [VALUE_BITS-1:0] cap_q  [CHANNELS];
	logic [VALUE_BITS-1:0] pub_q  [CHANNELS];
	logic [VALUE_BITS-1:0] hist_q [CHANNELS][ppmd_pkg::HDEPTH];

	logic [VALUE_BITS-1:0] cap_nxt [CHANNELS];
	logic [VALUE_BITS-1:0] pub_nxt [CHANNELS];
	logic [SLOT_W-1:0]     slot_nxt;
	logic                  sync_nxt;
	logic [VALUE_BITS-1:0] sat_val;
	logic                  in_win;

	logic                  out_valid_q, out_last_q, out_user_q;
	ppmd_pkg::out_data_t   out_data_q;
	logic                  out_free;
	logic                  emit;

	ppmd_pkg::alu_req_t alu_req;
	ppmd_pkg::alu_rsp_t alu_rsp;

	ppmd_pkg::in_data_t    in_d;
	logic [VALUE_BITS-1:0] ha, hb, hc, voted;
	logic [31:0]           chan_ext, slot_ext;

	ppmd_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign in_d      = s_tdata;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	// output register loads a new result this cycle
	assign emit      = out_free && (state_q == ST_EMIT || state_q == ST_VOTE);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	assign ha = hist_q[chan_q][0];
	assign hb = hist_q[chan_q][1];
	assign hc = hist_q[chan_q][2];

	assign chan_ext = 32'(chan_q);
	assign slot_ext = 32'(slot_q);

	// shared adder operand select
	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_MUL: begin
				alu_req.a = acc_q;
				alu_req.b = mplier_q[0] ? mcand_q : 32'd0;
			end
			ST_ADDCV: begin
				alu_req.a = acc_q;
				alu_req.b = 32'(cv_q);
			end
			ST_DELTA: begin
				alu_req.a   = acc_q;
				alu_req.b   = prev_q;
				alu_req.sub = 1'b1;
			end
			ST_CMIN: begin
				alu_req.a   = delta_q;
				alu_req.b   = 32'(pmin_q);
				alu_req.sub = 1'b1;
			end
			ST_CMAX: begin
				alu_req.a   = 32'(pmax_q);
				alu_req.b   = delta_q;
				alu_req.sub = 1'b1;
			end
			ST_CGAP: begin
				alu_req.a   = delta_q;
				alu_req.b   = 32'(gap_q);
				alu_req.sub = 1'b1;
			end
			ST_VOTE: begin
				alu_req.a   = 32'(hb);
				alu_req.b   = 32'(ha);
				alu_req.sub = 1'b1;
			end
			default: alu_req = '0;
		endcase
	end

	// vote: a if a matches b or c, else b if b matches c, else max(a, b)
	always_comb begin
		if (ha == hb || ha == hc) begin
			voted = ha;
		end else if (hb == hc) begin
			voted = hb;
		end else begin
			voted = alu_rsp.carry ? hb : ha;
		end
	end

	assign sat_val = (delta_q > VALUE_MAX) ? VALUE_MAX[VALUE_BITS-1:0]
	                                       : delta_q[VALUE_BITS-1:0];
	assign in_win  = ge_min_q && le_max_q;

	// frame capture decision, applied in ST_UPD
	always_comb begin
		cap_nxt  = cap_q;
		pub_nxt  = pub_q;
		slot_nxt = slot_q;
		sync_nxt = sync_q;
		if (sync_q) begin
			if (in_win) begin
				if (slot_q < SLOT_W'(CHANNELS)) begin
					cap_nxt[slot_q[CH_W-1:0]] = sat_val;
					slot_nxt = slot_q + SLOT_W'(1);
				end
				if (slot_nxt >= SLOT_W'(CHANNELS)) begin
					for (int i = 0; i < CHANNELS; i++) begin
						pub_nxt[i] = cap_nxt[i];
					end
					sync_nxt = 1'b0;
				end
			end else if (ge_gap_q) begin
				// gap ends a running frame: publish the partial frame
				for (int i = 0; i < CHANNELS; i++) begin
					if (SLOT_W'(i) < slot_q) begin
						pub_nxt[i] = cap_q[i];
					end
				end
				sync_nxt = 1'b1;
				slot_nxt = '0;
			end else begin
				sync_nxt = 1'b0;
			end
		end else if (ge_gap_q) begin
			sync_nxt = 1'b1;
			slot_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q     <= ppmd_pkg::TIMER_PERIOD_RST;
			pmin_q   <= ppmd_pkg::PULSE_MIN_RST;
			pmax_q   <= ppmd_pkg::PULSE_MAX_RST;
			gap_q    <= ppmd_pkg::SYNC_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppmd_pkg::REG_TIMER_PERIOD: tp_q   <= cfg_data;
				ppmd_pkg::REG_PULSE_MIN:    pmin_q <= cfg_data;
				ppmd_pkg::REG_PULSE_MAX:    pmax_q <= cfg_data;
				ppmd_pkg::REG_SYNC_GAP:     gap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			cv_q        <= '0;
			step_q      <= '0;
			prev_q      <= '0;
			delta_q     <= '0;
			ge_min_q    <= 1'b0;
			le_max_q    <= 1'b0;
			ge_gap_q    <= 1'b0;
			sync_q      <= 1'b0;
			slot_q      <= '0;
			edges_q     <= '0;
			hslot_q     <= '0;
			chan_q      <= '0;
			cap_q       <= '{default: '0};
			pub_q       <= '{default: '0};
			hist_q      <= '{default: '{default: '0}};
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_user_q  <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0]) begin
							state_q <= ST_PUSH;
						end else begin
							acc_q    <= '0;
							mcand_q  <= in_d.period_count;
							mplier_q <= tp_q;
							cv_q     <= in_d.counter_value;
							step_q   <= '0;
							state_q  <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					acc_q    <= alu_rsp.sum;
					mcand_q  <= {mcand_q[30:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[ppmd_pkg::TP_W-1:1]};
					step_q   <= step_q + ppmd_pkg::STEP_W'(1);
					if (step_q == ppmd_pkg::STEP_W'(ppmd_pkg::TP_W - 1)) begin
						state_q <= ST_ADDCV;
					end
				end
				ST_ADDCV: begin
					acc_q   <= alu_rsp.sum;
					state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					delta_q <= alu_rsp.sum;
					prev_q  <= acc_q;
					state_q <= ST_CMIN;
				end
				ST_CMIN: begin
					ge_min_q <= alu_rsp.carry;
					state_q  <= ST_CMAX;
				end
				ST_CMAX: begin
					le_max_q <= alu_rsp.carry;
					state_q  <= ST_CGAP;
				end
				ST_CGAP: begin
					ge_gap_q <= alu_rsp.carry;
					state_q  <= ST_UPD;
				end
				ST_UPD: begin
					cap_q  <= cap_nxt;
					pub_q  <= pub_nxt;
					slot_q <= slot_nxt;
					sync_q <= sync_nxt;
					if (edges_q < ppmd_pkg::EDGE_SAT) begin
						edges_q <= edges_q + ppmd_pkg::EDGE_W'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_user_q <= 1'b0;
						out_last_q <= 1'b1;
						out_data_q <= '{pad: '0, edge_count: edges_q,
							captured_count: slot_ext[3:0], synced: sync_q,
							pulse_width: delta_q, channel_value: '0, channel_index: '0};
						state_q    <= ST_IDLE;
					end
				end
				ST_PUSH: begin
					for (int k = 0; k < CHANNELS; k++) begin
						hist_q[k][hslot_q] <= pub_q[k];
					end
					hslot_q <= (hslot_q == 2'd2) ? 2'd0 : hslot_q + 2'd1;
					chan_q  <= '0;
					state_q <= ST_VOTE;
				end
				ST_VOTE: begin
					if (out_free) begin
						out_user_q <= 1'b1;
						out_last_q <= (chan_ext == 32'(CHANNELS - 1));
						out_data_q <= '{pad: '0, edge_count: '0, captured_count: '0,
							synced: 1'b0, pulse_width: '0, channel_value: voted[11:0],
							channel_index: chan_ext[2:0]};
						if (chan_ext == 32'(CHANNELS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							chan_q <= chan_q + CH_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// an accepted item always takes the sequencer out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sequencer ready right after an input transfer");

	// edge counter moves by one step at a time and never past saturation
	a_edges_step: assert property (@(posedge clk) disable iff (!arst_n)
		edges_q != $past(edges_q) |->
			edges_q == $past(edges_q) + ppmd_pkg::EDGE_W'(1) &&
			edges_q <= ppmd_pkg::EDGE_SAT)
		else $error("edge counter jumped");

	// slot count only restarts at zero or advances by one, bounded by CHANNELS
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q != $past(slot_q) |->
			(slot_q == '0 || slot_q == $past(slot_q) + SLOT_W'(1)) &&
			slot_q <= SLOT_W'(CHANNELS))
		else $error("slot count out of sequence");

	// history pointer stays within the three-entry ring
	a_hslot_range: assert property (@(posedge clk) disable iff (!arst_n)
		hslot_q != $past(hslot_q) |-> hslot_q != 2'd3)
		else $error("history pointer out of range");

endmodule

[bench/tb.sv]
// Self-checking bench for ppm_decoder_with_vote_filter: drives edge and sample
// transfers, predicts every result in-bench and compares field by field.
// Depends on ppmd_pkg and the design sources; no other files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS     = 8;
	localparam int VALUE_BITS   = 12;
	localparam int RANDOM_ITEMS = 225;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	localparam logic MODE_EDGE   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [31:0] VALUE_MAX = (32'd1 << VALUE_BITS) - 32'd1;

	typedef struct packed {
		logic                        is_channel;
		logic [2:0]                  index;
		logic [11:0]                 value;
		logic                        last;
		logic [31:0]                 width;
		logic                        synced;
		logic [3:0]                  captured;
		logic [ppmd_pkg::EDGE_W-1:0] edges;
	} ppm_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [47:0]                    s_tdata = '0;
	logic [0:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [63:0]                    m_tdata;
	logic [0:0]                     m_tuser;
	logic                           m_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ppmd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ppmd_pkg::CFG_W-1:0]     cfg_data = '0;

	ppm_decoder_with_vote_filter #(
		.CHANNELS(CHANNELS),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// decoder shadow: configuration
	logic [15:0] cfg_period, cfg_pulse_min, cfg_pulse_max, cfg_sync_gap;
	// decoder shadow: state
	logic [31:0]                 edge_time_q;
	logic                        in_frame;
	logic [3:0]                  slots_filled;
	logic [VALUE_BITS-1:0]       slot_width [CHANNELS];
	logic [VALUE_BITS-1:0]       channel_out [CHANNELS];
	logic [VALUE_BITS-1:0]       vote_hist [CHANNELS][ppmd_pkg::HDEPTH];
	logic [1:0]                  vote_ptr;
	logic [ppmd_pkg::EDGE_W-1:0] edge_tally;

	ppm_result_t pending_results [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          steady = 1'b0;    // no idling on either side while set

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 18);
	end

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		ppmd_pkg::out_data_t got;
		ppm_result_t         want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tuser=%0h tdata=%0h",
					$time, m_tuser, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("is_channel", 32'(want.is_channel), 32'(m_tuser[0]));
				check_field("channel_index", 32'(want.index), 32'(got.channel_index));
				check_field("channel_value", 32'(want.value), 32'(got.channel_value));
				check_field("last", 32'(want.last), 32'(m_tlast));
				check_field("pulse_width", want.width, got.pulse_width);
				check_field("synced", 32'(want.synced), 32'(got.synced));
				check_field("captured_count", 32'(want.captured), 32'(got.captured_count));
				check_field("edge_count", 32'(want.edges), 32'(got.edge_count));
			end
		end
	end

	task automatic reset_decoder_shadow();
		cfg_period    = ppmd_pkg::TIMER_PERIOD_RST;
		cfg_pulse_min = ppmd_pkg::PULSE_MIN_RST;
		cfg_pulse_max = ppmd_pkg::PULSE_MAX_RST;
		cfg_sync_gap  = ppmd_pkg::SYNC_GAP_RST;
		edge_time_q   = '0;
		in_frame      = 1'b0;
		slots_filled  = '0;
		vote_ptr      = '0;
		edge_tally    = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			slot_width[i]  = '0;
			channel_out[i] = '0;
			for (int j = 0; j < ppmd_pkg::HDEPTH; j++)
				vote_hist[i][j] = '0;
		end
	endtask

	task automatic latch_frame(int n);
		for (int i = 0; i < n && i < CHANNELS; i++)
			channel_out[i] = slot_width[i];
	endtask

	task automatic decode_edge(logic [31:0] pc, logic [15:0] cv);
		logic [63:0] stamp;
		logic [31:0] now, width;
		ppm_result_t r;
		stamp = {32'd0, pc} * {48'd0, cfg_period};
		now = stamp[31:0] + {16'd0, cv};
		width = now - edge_time_q;
		edge_time_q = now;
		if (edge_tally < ppmd_pkg::EDGE_SAT)
			edge_tally++;
		if (in_frame) begin
			if (width >= cfg_pulse_min && width <= cfg_pulse_max) begin
				if (slots_filled < CHANNELS) begin
					slot_width[slots_filled] = (width > VALUE_MAX) ? VALUE_MAX[VALUE_BITS-1:0]
						: width[VALUE_BITS-1:0];
					slots_filled++;
				end
				if (slots_filled >= CHANNELS) begin
					latch_frame(int'(slots_filled));
					in_frame = 1'b0;
				end
			end else if (width >= cfg_sync_gap) begin
				// gap inside a running frame: publish what was captured, restart
				latch_frame(int'(slots_filled));
				in_frame = 1'b1;
				slots_filled = '0;
			end else begin
				in_frame = 1'b0;
			end
		end else if (width >= cfg_sync_gap) begin
			in_frame = 1'b1;
			slots_filled = '0;
		end
		r = '0;
		r.last     = 1'b1;
		r.width    = width;
		r.synced   = in_frame;
		r.captured = slots_filled;
		r.edges    = edge_tally;
		pending_results.push_back(r);
	endtask

	function automatic logic [VALUE_BITS-1:0] majority_of3(logic [VALUE_BITS-1:0] a,
		logic [VALUE_BITS-1:0] b, logic [VALUE_BITS-1:0] c);
		if (a == b || a == c)
			return a;
		if (b == c)
			return b;
		return (a > b) ? a : b;
	endfunction

	task automatic filter_sample();
		ppm_result_t r;
		for (int k = 0; k < CHANNELS; k++)
			vote_hist[k][vote_ptr] = channel_out[k];
		for (int k = 0; k < CHANNELS; k++) begin
			r = '0;
			r.is_channel = 1'b1;
			r.index      = k[2:0];
			r.value      = 12'(majority_of3(vote_hist[k][0], vote_hist[k][1], vote_hist[k][2]));
			r.last       = (k == CHANNELS - 1);
			pending_results.push_back(r);
		end
		vote_ptr = (vote_ptr == ppmd_pkg::HDEPTH - 1) ? 2'd0 : vote_ptr + 2'd1;
	endtask

	// one input transfer; the sender idles now and then before it
	task automatic send_item(logic mode, logic [31:0] pc, logic [15:0] cv);
		ppmd_pkg::in_data_t d;
		if (!steady && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		d.period_count  = pc;
		d.counter_value = cv;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_EDGE)
			decode_edge(pc, cv);
		else
			filter_sample();
	endtask

	// edge whose timestamp lands width after the previous one, given the period
	task automatic send_edge_after(logic [31:0] width);
		logic [31:0] target;
		target = edge_time_q + width;
		if (cfg_period == 0)
			send_item(MODE_EDGE, $urandom, target[15:0]);
		else
			send_item(MODE_EDGE, target / cfg_period, 16'(target % cfg_period));
	endtask

	task automatic send_sample();
		send_item(MODE_SAMPLE, $urandom, 16'($urandom));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [ppmd_pkg::CFG_IDX_W-1:0] idx,
		logic [ppmd_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ppmd_pkg::REG_TIMER_PERIOD: cfg_period = value;
			ppmd_pkg::REG_PULSE_MIN:    cfg_pulse_min = value;
			ppmd_pkg::REG_PULSE_MAX:    cfg_pulse_max = value;
			ppmd_pkg::REG_SYNC_GAP:     cfg_sync_gap = value;
			default:                    ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_settings(logic [15:0] period, logic [15:0] pmin, logic [15:0] pmax,
		logic [15:0] gap);
		wait_idle();
		write_register(ppmd_pkg::REG_TIMER_PERIOD, period);
		write_register(ppmd_pkg::REG_PULSE_MIN, pmin);
		write_register(ppmd_pkg::REG_PULSE_MAX, pmax);
		write_register(ppmd_pkg::REG_SYNC_GAP, gap);
	endtask

	task automatic test_reset_state();
		send_sample();                               // all-zero history
		send_item(MODE_EDGE, 32'd0, 16'd0);          // zero width, no sync
		send_item(MODE_EDGE, 32'hFFFF_FFFF, 16'hFFFF); // wrapped stamp, huge gap
	endtask

	task automatic test_frame_decode();
		send_edge_after(32'd3000);                   // gap while synced, empty publish
		send_edge_after(32'd800);
		send_edge_after(32'd2200);
		for (int i = 0; i < CHANNELS - 2; i++)
			send_edge_after($urandom_range(900, 2100));
		send_edge_after(32'd1000);                   // frame done, unsynced: ignored
		send_sample();
		send_edge_after(32'd5000);
		send_edge_after(32'd1500);
		send_edge_after(32'd1600);
		send_edge_after(32'd2600);                   // short frame ended by a gap
		send_edge_after(32'd100);                    // runt drops sync
		send_sample();
		send_sample();
	endtask

	task automatic test_register_extremes();
		wait_idle();
		write_register(8'd4, 16'hFFFF);              // unknown indexes change nothing
		write_register(8'hFF, 16'h0000);
		write_settings(16'd0, 16'd100, 16'hFFFF, 16'd3000);
		send_item(MODE_EDGE, $urandom, 16'd0);       // period zero: stamp is the counter
		send_edge_after(32'd5000);                   // in window and past gap, saturates
		send_sample();
	endtask

	task automatic test_random_traffic();
		int          sent;
		int          pick;
		int          n_pulses;
		logic [15:0] pmin, pmax;
		logic [31:0] width;
		sent = 0;
		for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
			case (phase % 6)
				0: write_settings(16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
				1: write_settings(16'hFFFF, 16'd1000, 16'd2000, 16'd0);
				2: write_settings(16'd0, 16'd100, 16'd5000, 16'd8000);
				3: write_settings(ppmd_pkg::TIMER_PERIOD_RST, ppmd_pkg::PULSE_MIN_RST,
					ppmd_pkg::PULSE_MAX_RST, ppmd_pkg::SYNC_GAP_RST);
				default: begin
					pmin = 16'($urandom_range(0, 3000));
					pmax = pmin + 16'($urandom_range(0, 3000));
					wait_idle();
					write_register(8'($urandom_range(4, 255)), 16'($urandom));
					write_settings(16'($urandom_range(1, 65535)), pmin, pmax,
						($urandom_range(3) == 0) ? 16'($urandom)
							: 16'(pmax + $urandom_range(1, 5000)));
				end
			endcase
			steady = (phase == 3);
			for (int j = 0; j < 6 && sent < RANDOM_ITEMS; j++) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					send_edge_after(cfg_sync_gap + $urandom_range(0, 2000));
					n_pulses = ($urandom_range(3) == 0) ? $urandom_range(0, CHANNELS - 1) : CHANNELS;
					for (int k = 0; k < n_pulses; k++) begin
						if ($urandom_range(9) == 0)
							width = $urandom_range(0, 2 * cfg_sync_gap + 10);
						else if (cfg_pulse_max >= cfg_pulse_min)
							width = cfg_pulse_min + $urandom_range(0, cfg_pulse_max - cfg_pulse_min);
						else
							width = $urandom_range(0, 65535);
						send_edge_after(width);
					end
					sent += n_pulses + 1;
				end else if (pick < 72) begin
					send_sample();
					sent++;
				end else if (pick < 90) begin
					send_item(MODE_EDGE, $urandom, 16'($urandom));
					sent++;
				end else begin
					// land just below the wrap point so the next widths roll over
					send_edge_after(32'hFFFF_FFFF - $urandom_range(0, 3000) - edge_time_q);
					sent++;
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		reset_decoder_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_frame_decode();
		test_register_extremes();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
